[rtl/esg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package esg_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_SIZE   = 3;

  localparam int CFG_W  = 11;
  localparam int IDX_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W  = (WID_W > CFG_W) ? WID_W : CFG_W;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  localparam int GRAY_W = 8;
  localparam int PIX_W  = GRAY_W + 1;
  localparam int POS_W  = 10;
  localparam int GRAD_W = 11;
  localparam int SUM_W  = GRAY_W + 2;
  localparam int DIFF_W = GRAY_W + 1;

  localparam logic [GRAY_W-1:0] EDGE_MARK = 8'd255;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  typedef struct packed {
    logic             row_ok;
    logic             col_ok;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_t;

endpackage

`default_nettype wire

[rtl/esg_pix_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface esg_pix_if;
  logic                       valid;
  logic                       ready;
  logic [esg_pkg::GRAY_W-1:0] gray_level;
  logic [esg_pkg::GRAY_W-1:0] edge_level;

  modport source (output valid, output gray_level, output edge_level, input ready);
  modport sink   (input valid, input gray_level, input edge_level, output ready);
endinterface

`default_nettype wire

[rtl/esg_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface esg_res_if;
  logic                              valid;
  logic                              ready;
  logic        [esg_pkg::POS_W-1:0]  pixel_row;
  logic        [esg_pkg::POS_W-1:0]  pixel_col;
  logic signed [esg_pkg::GRAD_W-1:0] grad_x;
  logic signed [esg_pkg::GRAD_W-1:0] grad_y;

  modport source (output valid, output pixel_row, output pixel_col, output grad_x,
                  output grad_y, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, input grad_x,
                  input grad_y, output ready);
endinterface

`default_nettype wire

[rtl/esg_line_buf.sv]
`timescale 1ns / 1ps
`default_nettype none

module esg_line_buf (
  input  wire logic                      clk_i,
  input  wire logic                      rd_en_i,
  input  wire logic [esg_pkg::IDX_W-1:0] rd_addr_i,
  input  wire logic                      wr_en_i,
  input  wire logic [esg_pkg::IDX_W-1:0] wr_addr_i,
  input  wire logic [esg_pkg::PIX_W-1:0] wr_a_i,
  input  wire logic [esg_pkg::PIX_W-1:0] wr_b_i,
  output logic      [esg_pkg::PIX_W-1:0] rd_a_o,
  output logic      [esg_pkg::PIX_W-1:0] rd_b_o
);
  import esg_pkg::*;

  logic [PIX_W-1:0] mem_a [MAX_WIDTH];
  logic [PIX_W-1:0] mem_b [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[wr_addr_i] <= wr_a_i;
      mem_b[wr_addr_i] <= wr_b_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_o <= mem_a[rd_addr_i];
      rd_b_o <= mem_b[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/esg_col_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module esg_col_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              shift_i,
  input  wire esg_pkg::col_t                     col_i,
  output esg_pkg::col_t                          col_o,
  output logic        [esg_pkg::SUM_W-1:0]       sum_o,
  output logic signed [esg_pkg::DIFF_W-1:0]      diff_o
);
  import esg_pkg::*;

  col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o  = col_q;
  assign sum_o  = SUM_W'(col_q.top[GRAY_W-1:0]) + {1'b0, col_q.mid[GRAY_W-1:0], 1'b0}
                + SUM_W'(col_q.bot[GRAY_W-1:0]);
  assign diff_o = $signed({1'b0, col_q.bot[GRAY_W-1:0]})
                - $signed({1'b0, col_q.top[GRAY_W-1:0]});

endmodule

`default_nettype wire

[rtl/edge_masked_sobel_gradient.sv]
`timescale 1ns / 1ps
`default_nettype none

// Edge-masked 3x3 Sobel gradient over a raster-order pixel stream.
// pix_i carries one pixel per transfer (gray_level, edge_level); res_o carries
// one result (pixel_row, pixel_col, grad_x, grad_y) for each interior pixel
// whose edge_level is 255. Border and non-edge pixels give no result.
// The user must write image_width and image_height (cfg_we_i/cfg_idx_i/
// cfg_data_i) only while the stream is idle; the block does not enforce it.
// Out-of-range values are saturated. Throughput is one pixel per cycle unless
// res_o stalls: the line stores are read and written once per pixel, and the
// three column cells shift once per pixel. A result is registered on res_o
// after its window's last pixel (one row below, one column right) passes s1/s2.
// Reset clears the position counters, the window cells and the pipeline,
// and loads 640 x 480; line store contents are undefined until written.
// When res_o stalls with a result held, the pipeline keeps moving until the
// next result needs the output register, then pix_i.ready drops.
module edge_masked_sobel_gradient (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire esg_pkg::cfg_idx_e         cfg_idx_i,
  input  wire logic [esg_pkg::CFG_W-1:0] cfg_data_i,
  esg_pix_if.sink                        pix_i,
  esg_res_if.source                      res_o
);
  import esg_pkg::*;

  logic [CFG_W-1:0] image_width_q, image_height_q;
  logic [IDX_W-1:0] column_count_q, column_count_d;
  logic [ROW_W-1:0] row_count_q, row_count_d;

  logic [CMP_W-1:0] width_ext, width_eff, col_ext, col_sel;
  logic [CFG_W-1:0] height_eff;
  logic             col_last, row_last;

  logic             advance, accept;
  logic             s1_valid_q, s2_valid_q;
  pos_t             pos_d, s1_pos_q, s2_pos_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [PIX_W-1:0] s1_cur_q, cur_d;
  logic [PIX_W-1:0] rd_a, rd_b;
  logic             shift, s2_hit;

  col_t                     cell_in  [3];
  col_t                     cell_out [3];
  logic        [SUM_W-1:0]  cell_sum [3];
  logic signed [DIFF_W-1:0] cell_diff[3];

  logic signed [GRAD_W-1:0] grad_x_d, grad_y_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= CFG_W'(640);
      image_height_q <= CFG_W'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    width_ext = CMP_W'(image_width_q);
    if (width_ext < CMP_W'(MIN_SIZE)) begin
      width_eff = CMP_W'(MIN_SIZE);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (image_height_q < CFG_W'(MIN_SIZE)) begin
      height_eff = CFG_W'(MIN_SIZE);
    end else if (image_height_q > CFG_W'(MAX_HEIGHT)) begin
      height_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      height_eff = image_height_q;
    end
    col_ext  = CMP_W'(column_count_q);
    col_sel  = (col_ext >= width_eff) ? width_eff - CMP_W'(1) : col_ext;
    col_last = (col_ext + CMP_W'(1)) >= width_eff;
    row_last = (CFG_W'(row_count_q) + CFG_W'(1)) >= height_eff;
  end

  always_comb begin
    column_count_d = column_count_q;
    row_count_d    = row_count_q;
    if (col_last) begin
      column_count_d = '0;
      row_count_d    = row_last ? '0 : row_count_q + ROW_W'(1);
    end else begin
      column_count_d = column_count_q + IDX_W'(1);
    end
  end

  always_comb begin
    pos_d.row_ok = row_count_q >= ROW_W'(2);
    pos_d.col_ok = col_sel >= CMP_W'(2);
    pos_d.row    = POS_W'(row_count_q - ROW_W'(1));
    pos_d.col    = POS_W'(col_sel - CMP_W'(1));
    cur_d        = {(pix_i.edge_level == EDGE_MARK), pix_i.gray_level};
  end

  assign s2_hit  = s2_valid_q && s2_pos_q.row_ok && s2_pos_q.col_ok
                 && cell_out[1].mid[PIX_W-1];
  assign advance = !s2_hit || !res_o.valid || res_o.ready;
  assign accept  = pix_i.valid && advance;
  assign shift   = advance && s1_valid_q;
  assign pix_i.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      row_count_q    <= '0;
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      if (accept) begin
        column_count_q <= column_count_d;
        row_count_q    <= row_count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q <= pos_d;
      s1_idx_q <= col_sel[IDX_W-1:0];
      s1_cur_q <= cur_d;
    end
    if (advance) begin
      s2_pos_q <= s1_pos_q;
    end
  end

  esg_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_sel[IDX_W-1:0]),
    .wr_en_i   (shift),
    .wr_addr_i (s1_idx_q),
    .wr_a_i    (s1_cur_q),
    .wr_b_i    (rd_a),
    .rd_a_o    (rd_a),
    .rd_b_o    (rd_b)
  );

  assign cell_in[2] = '{top: rd_b, mid: rd_a, bot: s1_cur_q};
  assign cell_in[1] = cell_out[2];
  assign cell_in[0] = cell_out[1];

  for (genvar i = 0; i < 3; i++) begin : g_cell
    esg_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .col_i   (cell_in[i]),
      .col_o   (cell_out[i]),
      .sum_o   (cell_sum[i]),
      .diff_o  (cell_diff[i])
    );
  end

  always_comb begin
    grad_x_d = $signed({1'b0, cell_sum[2]}) - $signed({1'b0, cell_sum[0]});
    grad_y_d = $signed({{2{cell_diff[0][DIFF_W-1]}}, cell_diff[0]})
             + $signed({cell_diff[1][DIFF_W-1], cell_diff[1], 1'b0})
             + $signed({{2{cell_diff[2][DIFF_W-1]}}, cell_diff[2]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_o.valid <= 1'b0;
    end else if (advance && s2_hit) begin
      res_o.valid <= 1'b1;
    end else if (res_o.ready) begin
      res_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_hit) begin
      res_o.pixel_row <= s2_pos_q.row;
      res_o.pixel_col <= s2_pos_q.col;
      res_o.grad_x    <= grad_x_d;
      res_o.grad_y    <= grad_y_d;
    end
  end

endmodule

`default_nettype wire
